// File: rtl/forq_pkg.sv
// ----------------------------------------------------------------------------
// forq_pkg
// Shared types and constants for the frame ordered release queue.
// ----------------------------------------------------------------------------
package forq_pkg;

    localparam int CAPACITY     = 16;
    localparam int FRAME_BITS   = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    // Stream packing
    localparam int S_TDATA_RAW = FRAME_BITS + PAYLOAD_BITS;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_RAW = PAYLOAD_BITS + FRAME_BITS + CNT_W;
    localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TUSER_W   = 2;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_EXTRACT = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_HOLD = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic exec;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

// File: rtl/frame_ordered_release_queue_top.sv
// ----------------------------------------------------------------------------
// frame_ordered_release_queue_top
// Bounded queue of payloads kept sorted by due frame, stable for equal frames.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one command per transaction: insert an entry,
//   extract the head if its frame is not above the given current frame,
//   or clear the queue. Master channel returns exactly one result per
//   command: found/overflow flags, the extracted payload and frame (zero
//   when nothing was extracted) and the occupancy after the command.
//   The result is valid in the cycle after the command transaction.
//   Throughput: one command per cycle while the receiver takes each
//   result; all cells of the sorted shift register compare against the new
//   frame in the same cycle, so a command executes in its accepting cycle.
//   An insert into a full queue (16 entries) is dropped and flagged.
//   When the receiver stalls, the result is held and a new command is
//   accepted only in a cycle where the held result is taken.
//   Reset empties the queue and drops any held result; entry contents
//   are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module frame_ordered_release_queue_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [31:0] frame, [63:32] payload
    input  logic [forq_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [1:0] action
    input  logic [forq_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] payload_out, [63:32] due_frame, [68:64] occupancy, rest zero
    output logic [forq_pkg::M_TDATA_W-1:0] o_m_tdata,
    // [0] found, [1] overflow
    output logic [forq_pkg::M_TUSER_W-1:0] o_m_tuser
);
    import forq_pkg::*;

    t_dp_cmd                 w_cmd;
    t_dp_stat                w_stat;
    logic                    w_found;
    logic                    w_ovf;
    logic [PAYLOAD_BITS-1:0] w_pout;
    logic [FRAME_BITS-1:0]   w_dfrm;
    logic [CNT_W-1:0]        w_occ;

    forq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    forq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_action      (i_s_tuser[1:0]),
        .i_frame       (i_s_tdata[FRAME_BITS-1:0]),
        .i_payload     (i_s_tdata[FRAME_BITS +: PAYLOAD_BITS]),
        .o_found       (w_found),
        .o_payload_out (w_pout),
        .o_due_frame   (w_dfrm),
        .o_overflow    (w_ovf),
        .o_occupancy   (w_occ)
    );

    // Pack the result
    assign o_m_tdata = M_TDATA_W'({w_occ, w_dfrm, w_pout});
    assign o_m_tuser = {w_ovf, w_found};

endmodule

// File: rtl/forq_ctrl.sv
// ----------------------------------------------------------------------------
// forq_ctrl
// Handshake controller: one result register, taken over while it drains.
// ----------------------------------------------------------------------------
module forq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output forq_pkg::t_dp_cmd o_cmd,
    input  forq_pkg::t_dp_stat i_stat
);
    import forq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_s_tvalid && o_s_tready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (i_m_tready && !w_accept) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_HOLD: begin
                o_s_tready = i_m_tready;
                o_m_tvalid = 1'b1;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
        o_cmd.exec = w_accept;
    end

    // A transaction always leaves a result held in the next cycle
    a_exec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == ST_HOLD))
        else $error("result not held after transaction");

    // Queue cannot be full and empty at once
    a_stat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_stat.full && i_stat.empty))
        else $error("status full and empty together");

endmodule

// File: rtl/forq_dp.sv
// ----------------------------------------------------------------------------
// forq_dp
// Sorted shift register of entries with a registered result stage.
// ----------------------------------------------------------------------------
module forq_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  forq_pkg::t_dp_cmd                i_cmd,
    output forq_pkg::t_dp_stat               o_stat,
    input  logic [1:0]                       i_action,
    input  logic [forq_pkg::FRAME_BITS-1:0]  i_frame,
    input  logic [forq_pkg::PAYLOAD_BITS-1:0] i_payload,
    output logic                             o_found,
    output logic [forq_pkg::PAYLOAD_BITS-1:0] o_payload_out,
    output logic [forq_pkg::FRAME_BITS-1:0]  o_due_frame,
    output logic                             o_overflow,
    output logic [forq_pkg::CNT_W-1:0]       o_occupancy
);
    import forq_pkg::*;

    logic [FRAME_BITS-1:0]   r_frame   [CAPACITY];
    logic [PAYLOAD_BITS-1:0] r_payload [CAPACITY];
    logic [FRAME_BITS-1:0]   n_frame   [CAPACITY];
    logic [PAYLOAD_BITS-1:0] n_payload [CAPACITY];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_found, n_found;
    logic                    r_ovf, n_ovf;
    logic [PAYLOAD_BITS-1:0] r_pout, n_pout;
    logic [FRAME_BITS-1:0]   r_dfrm, n_dfrm;
    logic [CAPACITY-1:0]     w_le;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_due;
    t_action                 w_act;

    assign w_act   = t_action'(i_action);
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_due   = !w_empty && (r_frame[0] <= i_frame);

    assign o_stat.full  = w_full;
    assign o_stat.empty = w_empty;

    // Per cell: stored entry is valid and due no later than the new frame
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_le[i] = (CNT_W'(i) < r_count) && (r_frame[i] <= i_frame);
        end
    end

    // Next cell contents and result
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_frame[i]   = r_frame[i];
            n_payload[i] = r_payload[i];
        end
        n_count = r_count;
        n_found = 1'b0;
        n_ovf   = 1'b0;
        n_pout  = '0;
        n_dfrm  = '0;
        case (w_act)
            ACT_INSERT: begin
                if (w_full) begin
                    n_ovf = 1'b1;
                end else begin
                    // head cell takes the new entry unless it is due no later
                    if (!w_le[0]) begin
                        n_frame[0]   = i_frame;
                        n_payload[0] = i_payload;
                    end
                    // keep cells before the slot, drop the new entry in, shift the rest up
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (w_le[i]) begin
                            n_frame[i]   = r_frame[i];
                            n_payload[i] = r_payload[i];
                        end else if (w_le[i-1]) begin
                            n_frame[i]   = i_frame;
                            n_payload[i] = i_payload;
                        end else begin
                            n_frame[i]   = r_frame[i-1];
                            n_payload[i] = r_payload[i-1];
                        end
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_EXTRACT: begin
                if (w_due) begin
                    n_found = 1'b1;
                    n_pout  = r_payload[0];
                    n_dfrm  = r_frame[0];
                    // advance every cell toward the head
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        n_frame[i]   = r_frame[i+1];
                        n_payload[i] = r_payload[i+1];
                    end
                    n_count = r_count - CNT_W'(1);
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // Cells and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_frame[i]   <= n_frame[i];
                r_payload[i] <= n_payload[i];
            end
            r_found <= n_found;
            r_ovf   <= n_ovf;
            r_pout  <= n_pout;
            r_dfrm  <= n_dfrm;
        end
    end

    assign o_found       = r_found;
    assign o_overflow    = r_ovf;
    assign o_payload_out = r_pout;
    assign o_due_frame   = r_dfrm;
    assign o_occupancy   = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (w_act == ACT_INSERT) && w_full)
        |=> (r_ovf && (r_count == CNT_W'(CAPACITY))))
        else $error("insert into full queue not flagged");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (w_act == ACT_CLEAR)) |=> ((r_count == '0) && !r_found))
        else $error("clear left entries");

    a_extract_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (w_act == ACT_EXTRACT) && w_due)
        |=> (r_found && (r_count == $past(r_count) - CNT_W'(1))))
        else $error("extract did not remove head");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame ordered release queue. A scoreboard
// mirrors the sorted queue, predicts one result per accepted command and
// compares every returned result field by field. Directed commands cover
// empty, full, tie and wrap-edge cases; random traffic follows with fill
// and drain segments, random gaps on both channels, one long receiver
// stall and one sender pause until all results are back.
// ----------------------------------------------------------------------------
module tb;
    import forq_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int STEADY_FROM  = 1450;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AT      = 400;
    localparam int PAUSE_AT     = 900;

    typedef struct packed {
        logic                    found;
        logic [PAYLOAD_BITS-1:0] payload_out;
        logic [FRAME_BITS-1:0]   due_frame;
        logic                    overflow;
        logic [CNT_W-1:0]        occupancy;
    } queue_result_t;

    // Mirror of the sorted queue plus the results still owed by the block
    class release_queue_scoreboard;
        logic [FRAME_BITS-1:0]   frames [CAPACITY];
        logic [PAYLOAD_BITS-1:0] payloads [CAPACITY];
        int                      count;
        queue_result_t           pending [$];
        int                      errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // Apply one accepted command to the mirror and queue its result
        function void note_command(t_action act, logic [FRAME_BITS-1:0] frm,
                                   logic [PAYLOAD_BITS-1:0] pay);
            queue_result_t r;
            int            pos;
            r = '0;
            case (act)
                ACT_INSERT: begin
                    if (count >= CAPACITY) begin
                        r.overflow = 1'b1;
                    end else begin
                        // place after every entry with frame <= new frame
                        pos = 0;
                        while (pos < count && frames[pos] <= frm)
                            pos++;
                        for (int i = count; i > pos; i--) begin
                            frames[i]   = frames[i-1];
                            payloads[i] = payloads[i-1];
                        end
                        frames[pos]   = frm;
                        payloads[pos] = pay;
                        count++;
                    end
                end
                ACT_EXTRACT: begin
                    if (count > 0 && frames[0] <= frm) begin
                        r.found       = 1'b1;
                        r.payload_out = payloads[0];
                        r.due_frame   = frames[0];
                        for (int i = 1; i < count; i++) begin
                            frames[i-1]   = frames[i];
                            payloads[i-1] = payloads[i];
                        end
                        count--;
                    end
                end
                ACT_CLEAR: begin
                    count = 0;
                end
                default: begin
                end
            endcase
            r.occupancy = CNT_W'(count);
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            queue_result_t want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual tdata=%h tuser=%b",
                         $time, tdata, tuser);
                return;
            end
            want = pending.pop_front();
            compare_field("found", 64'(want.found), 64'(tuser[0]));
            compare_field("overflow", 64'(want.overflow), 64'(tuser[1]));
            compare_field("payload_out", 64'(want.payload_out),
                          64'(tdata[PAYLOAD_BITS-1:0]));
            compare_field("due_frame", 64'(want.due_frame),
                          64'(tdata[PAYLOAD_BITS +: FRAME_BITS]));
            compare_field("occupancy", 64'(want.occupancy),
                          64'(tdata[PAYLOAD_BITS+FRAME_BITS +: CNT_W]));
            compare_field("padding", 64'd0, 64'(tdata >> M_TDATA_RAW));
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function int failures();
            return errors;
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    // [31:0] frame, [63:32] payload
    logic [S_TDATA_W-1:0] i_s_tdata;
    // [1:0] action
    logic [S_TUSER_W-1:0] i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    // [31:0] payload_out, [63:32] due_frame, [68:64] occupancy, rest zero
    logic [M_TDATA_W-1:0] o_m_tdata;
    // [0] found, [1] overflow
    logic [M_TUSER_W-1:0] o_m_tuser;

    release_queue_scoreboard sb;
    logic                    hold_request;
    logic                    steady;

    frame_ordered_release_queue_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Free-running clock
    always #5 i_clk = ~i_clk;

    // Offer one command and hold it until the transaction completes
    task automatic send_command(input t_action act, input logic [FRAME_BITS-1:0] frm,
                                input logic [PAYLOAD_BITS-1:0] pay);
        logic ready;
        if (!steady && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pay, frm};
        i_s_tuser  <= act;
        do begin
            @(negedge i_clk);
            ready = o_s_tready;
            @(posedge i_clk);
        end while (!ready);
        sb.note_command(act, frm, pay);
    endtask

    // Stop offering and wait for every owed result
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        logic [FRAME_BITS-1:0] frame_base;
        logic [FRAME_BITS-1:0] frm;
        int                    mode;
        int                    ins_pct;
        int                    r;
        t_action               act;

        sb           = new();
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = ACT_NOP;
        hold_request = 1'b0;
        steady       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty extract, unused code, extremes and equal-frame order
        send_command(ACT_EXTRACT, 32'hFFFF_FFFF, 32'h0);
        send_command(ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(ACT_INSERT, 32'h0, 32'h0);
        send_command(ACT_INSERT, 32'd5, 32'hA5A5_0001);
        send_command(ACT_INSERT, 32'd5, 32'h5A5A_0002);
        send_command(ACT_EXTRACT, 32'd4, 32'h0);
        send_command(ACT_EXTRACT, 32'd4, 32'h0);
        send_command(ACT_EXTRACT, 32'd5, 32'h0);
        send_command(ACT_EXTRACT, 32'd5, 32'h0);
        // Fill to capacity with ties, then overflow, then clear
        for (int k = 0; k < CAPACITY - 1; k++)
            send_command(ACT_INSERT, FRAME_BITS'(k % 4),
                         (k % 2 == 0) ? 32'hFFFF_FFFF : PAYLOAD_BITS'(k));
        send_command(ACT_INSERT, 32'h0, 32'h1234_5678);
        send_command(ACT_EXTRACT, 32'h0, 32'h0);
        send_command(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random: fill, drain and balanced segments around a moving frame
        frame_base = $urandom_range(0, 1000);
        mode       = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                mode = $urandom_range(0, 2);
                if ($urandom_range(0, 3) == 0)
                    frame_base = $urandom;
                else
                    frame_base = frame_base + $urandom_range(0, 8);
            end
            if (n == HOLD_AT)
                hold_request = 1'b1;
            if (n == PAUSE_AT)
                drain_results();
            if (n == STEADY_FROM)
                steady = 1'b1;
            ins_pct = (mode == 0) ? 70 : (mode == 1) ? 25 : 48;
            r       = $urandom_range(0, 99);
            if (r < ins_pct)
                act = ACT_INSERT;
            else if (r < 98)
                act = ACT_EXTRACT;
            else if (r < 99)
                act = ACT_CLEAR;
            else
                act = ACT_NOP;
            if ($urandom_range(0, 9) == 0)
                frm = $urandom;
            else if (act == ACT_INSERT)
                frm = frame_base + $urandom_range(0, 15);
            else
                frm = frame_base + $urandom_range(0, 20);
            send_command(act, frm, $urandom);
            if (act == ACT_EXTRACT)
                frame_base = frame_base + $urandom_range(0, 2);
        end

        // Wait for the last results, then watch for stray results
        drain_results();
        repeat (4) @(posedge i_clk);
        if (sb.failures() == 0 && sb.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Receiver: random short stalls, one long hold-off on request
    initial begin
        int                   idle_left;
        logic                 took;
        logic                 start_hold;
        logic                 seen_hold;
        logic                 calm;
        logic [M_TDATA_W-1:0] got_data;
        logic [M_TUSER_W-1:0] got_user;
        i_m_tready = 1'b0;
        idle_left  = 0;
        seen_hold  = 1'b0;
        forever begin
            @(negedge i_clk);
            took       = o_m_tvalid && i_m_tready;
            got_data   = o_m_tdata;
            got_user   = o_m_tuser;
            start_hold = hold_request && !seen_hold;
            calm       = steady;
            if (hold_request)
                seen_hold = 1'b1;
            @(posedge i_clk);
            if (took)
                sb.check_result(got_data, got_user);
            if (start_hold)
                idle_left = HOLD_CYCLES;
            else if (idle_left == 0 && !calm && $urandom_range(0, 4) == 0)
                idle_left = $urandom_range(1, 3);
            if (idle_left > 0) begin
                i_m_tready <= 1'b0;
                idle_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(negedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 sb.outstanding());
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/forq_pkg.sv
rtl/forq_ctrl.sv
rtl/forq_dp.sv
rtl/frame_ordered_release_queue_top.sv
tb/sv/tb.sv
